### rtl/core/rolling_sum_substring_search_assert.svh
// assertion macros used by the checker module
`ifndef ROLLING_SUM_SUBSTRING_SEARCH_ASSERT_SVH
`define ROLLING_SUM_SUBSTRING_SEARCH_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define RSS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rss assertion failed");

// consequent must hold in the cycle after the antecedent
`define RSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rss assertion failed");

`endif

### rtl/core/rss_pkg.sv
package rss_pkg;

  // default sizes
  localparam int              PATTERN_MAX_DEF = 16;
  localparam longint unsigned TEXT_MAX_DEF    = 64'd65536;

  // pattern storage: sixteen bytes in two 64-bit registers
  localparam int PAT_BYTES = 16;
  localparam int PLEN_W    = 5;
  localparam int REG_W     = 64;
  localparam int POS_W     = 16;

  typedef logic [PAT_BYTES-1:0][7:0] pat_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_PATTERN_LENGTH = 2'd0,
    CFG_PATTERN_LOW    = 2'd1,
    CFG_PATTERN_HIGH   = 2'd2
  } cfg_reg_t;

endpackage

### rtl/core/rss_cell.sv
module rss_cell #(
  parameter int J     = 0,
  parameter int LEN_W = 5
) (
  input  logic              clk,
  input  logic              shift,
  input  logic [LEN_W-1:0]  len,
  input  rss_pkg::pat_t     pat,
  input  logic [7:0]        byte_in,
  output logic [7:0]        byte_out,
  input  logic              eq_in,
  output logic              eq_out
);

  localparam int IW = (LEN_W > 5) ? LEN_W : 5;

  logic [7:0]    byte_q;
  logic [IW-1:0] pidx;
  logic          active;
  logic [7:0]    pbyte;

  // window tap, moves one place on each shift
  always_ff @(posedge clk) begin
    if (shift) begin
      byte_q <= byte_in;
    end
  end

  assign byte_out = byte_q;

  // this tap lines up with pattern byte len-1-J
  assign active = IW'(J) < IW'(len);
  assign pidx   = IW'(len) - IW'(J) - IW'(1);
  assign pbyte  = (pidx < IW'(rss_pkg::PAT_BYTES)) ? pat[pidx[3:0]] : 8'h00;

  // compare the incoming tap value, and along the match chain
  assign eq_out = eq_in & (~active | (byte_in == pbyte));

endmodule

### rtl/core/rolling_sum_substring_search.sv
// Streaming substring search: text bytes enter on s_* one per clock, back to back,
// and each is shifted into a row of PATTERN_MAX cells; every active cell compares its
// new byte with the pattern byte it lines up with, and the per-cell results are ANDed
// along the row, so a full window match is decided in the cycle the byte is accepted
// (equal bytes imply equal byte sums, so the sum prefilter needs no hardware of its
// own). One result per text appears on m_* the cycle after the byte marked tlast,
// with found and the start index of the first match. Bytes past TEXT_MAX are taken
// but not searched. Throughput is one byte per cycle; input stalls only while a
// result waits on m_tready. Pattern registers take effect on the next byte.
module rolling_sum_substring_search #(
  parameter int              PATTERN_MAX = rss_pkg::PATTERN_MAX_DEF,
  parameter longint unsigned TEXT_MAX    = rss_pkg::TEXT_MAX_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  // input stream
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [7:0]               s_tdata,   // [7:0] text_byte
  input  logic                     s_tlast,   // last_byte
  // result stream
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [23:0]              m_tdata,   // [0] found, [16:1] match_index, zero pad
  // configuration writes
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [rss_pkg::REG_W-1:0] cfg_data
);

  localparam int LEN_W = $clog2(PATTERN_MAX + 1);
  localparam int CNT_W = $clog2(TEXT_MAX + 1);
  localparam int EW    = (LEN_W > rss_pkg::PLEN_W) ? LEN_W : rss_pkg::PLEN_W;
  localparam int CW    = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;

  logic [rss_pkg::PLEN_W-1:0]  pattern_length;
  logic [rss_pkg::REG_W-1:0]   pattern_low;
  logic [rss_pkg::REG_W-1:0]   pattern_high;
  rss_pkg::pat_t               pat;
  logic [EW-1:0]               plen_w;
  logic [LEN_W-1:0]            len;

  logic [CNT_W-1:0]            bytes_seen;
  logic                        match_seen;
  logic [rss_pkg::POS_W-1:0]   first_pos;
  logic                        found_q;
  logic [rss_pkg::POS_W-1:0]   index_q;

  logic                        accept;
  logic                        saturated;
  logic                        shift;
  logic                        full;
  logic                        hit;
  logic                        match_seen_next;
  logic [rss_pkg::POS_W-1:0]   first_pos_next;
  logic [7:0]                  taps [PATTERN_MAX+1];
  logic                        eqs  [PATTERN_MAX+1];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= rss_pkg::PLEN_W'(1);
      pattern_low    <= '0;
      pattern_high   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rss_pkg::CFG_PATTERN_LENGTH: pattern_length <= cfg_data[rss_pkg::PLEN_W-1:0];
        rss_pkg::CFG_PATTERN_LOW:    pattern_low    <= cfg_data;
        rss_pkg::CFG_PATTERN_HIGH:   pattern_high   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign pat = {pattern_high, pattern_low};

  // effective length, clamped to 1..PATTERN_MAX
  assign plen_w = EW'(pattern_length);
  always_comb begin
    if (plen_w == '0) begin
      len = LEN_W'(1);
    end else if (plen_w > EW'(PATTERN_MAX)) begin
      len = LEN_W'(PATTERN_MAX);
    end else begin
      len = LEN_W'(plen_w);
    end
  end

  // handshake
  assign s_tready  = ~m_tvalid | m_tready;
  assign accept    = s_tvalid & s_tready;
  assign saturated = bytes_seen == CNT_W'(TEXT_MAX);
  assign shift     = accept & ~saturated;

  // window cell row
  assign taps[0] = s_tdata;
  assign eqs[0]  = 1'b1;

  for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
    rss_cell #(
      .J     (j),
      .LEN_W (LEN_W)
    ) u_cell (
      .clk      (clk),
      .shift    (shift),
      .len      (len),
      .pat      (pat),
      .byte_in  (taps[j]),
      .byte_out (taps[j+1]),
      .eq_in    (eqs[j]),
      .eq_out   (eqs[j+1])
    );
  end

  // first match tracking
  assign full            = (CW'(bytes_seen) + CW'(1)) >= CW'(len);
  assign hit             = shift & full & ~match_seen & eqs[PATTERN_MAX];
  assign match_seen_next = match_seen | hit;
  assign first_pos_next  = hit ? rss_pkg::POS_W'(CW'(bytes_seen) + CW'(1) - CW'(len))
                               : first_pos;

  // stream state, cleared after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
      match_seen <= 1'b0;
      first_pos  <= '0;
    end else if (accept) begin
      if (s_tlast) begin
        bytes_seen <= '0;
        match_seen <= 1'b0;
        first_pos  <= '0;
      end else begin
        bytes_seen <= saturated ? bytes_seen : bytes_seen + CNT_W'(1);
        match_seen <= match_seen_next;
        first_pos  <= first_pos_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept && s_tlast) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && s_tlast) begin
      found_q <= match_seen_next;
      index_q <= match_seen_next ? first_pos_next : '0;
    end
  end

  assign m_tdata = {7'd0, index_q, found_q};

endmodule

### rtl/core/rss_checker.sv
`include "rolling_sum_substring_search_assert.svh"

module rss_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  // a waiting result holds still
  `RSS_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // no match means a zero index
  `RSS_ASSERT_SAME(a_zero_index, m_tvalid && !m_tdata[0], m_tdata[16:1] == 16'd0)

  // input only backs up behind a waiting result
  `RSS_ASSERT_SAME(a_ready, !s_tready, m_tvalid && !m_tready)

  // a last byte gives a result next cycle
  `RSS_ASSERT_NEXT(a_result, s_tvalid && s_tready && s_tlast, m_tvalid)

  // a result only follows a last byte
  `RSS_ASSERT_SAME(a_cause, $rose(m_tvalid), $past(s_tvalid && s_tready && s_tlast))

endmodule

bind rolling_sum_substring_search rss_checker u_rss_checker (.*);
